FILE: sv/sim32_pkg.sv
// Shared types, constants and word functions for the Simon 32/64 cipher block.
// No dependencies; every other file of the block but sim32_ram imports this package.
package sim32_pkg;

	localparam int BLOCK_W        = 32;
	localparam int WORD_W         = 16;
	localparam int KEY_W          = 64;
	localparam int KEY_BYTES_W    = 4;
	localparam int ROUND_COUNT_W  = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int MAX_ROUNDS_DEF = 64;
	localparam int DEFAULT_ROUNDS = 32;
	localparam int Z0_PERIOD      = 62;

	localparam logic [63:0]       Z0_SEQ   = 64'h19C3522FB386A45F;
	localparam logic [WORD_W-1:0] RK_CONST = 16'h0003;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_VALUE   = 2'd0,
		REG_KEY_BYTES   = 2'd1,
		REG_ROUND_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_KSTART,
		ST_EXPAND,
		ST_IDLE,
		ST_PRIME,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ks_ctrl_t;

	typedef struct packed {
		logic load;
		logic prime;
		logic step;
	} rnd_ctrl_t;

	function automatic logic [WORD_W-1:0] rol16(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] ror16(input logic [WORD_W-1:0] x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	// Simon round function on one 16-bit word.
	function automatic logic [WORD_W-1:0] simon_f(input logic [WORD_W-1:0] x);
		return (rol16(x, 1) & rol16(x, 8)) ^ rol16(x, 2);
	endfunction

endpackage

FILE: sv/sim32_if.sv
// Handshake channels of the Simon 32/64 block: requests, results and register writes.
// Depends on sim32_pkg for the field widths.
interface sim32_req_if import sim32_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [BLOCK_W-1:0] block_in;

	modport source (output valid, output op, output block_in, input ready);
	modport sink (input valid, input op, input block_in, output ready);
endinterface

interface sim32_rsp_if import sim32_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BLOCK_W-1:0] block_out;

	modport source (output valid, output block_out, input ready);
	modport sink (input valid, input block_out, output ready);
endinterface

interface sim32_cfg_if import sim32_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [KEY_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/sim32_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sim32_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/sim32_keysched.sv
// Key expansion: a four-word shift register that emits one round key per cycle.
// Depends on sim32_pkg; its output is written into the round key RAM.
module sim32_keysched import sim32_pkg::*; #(
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ks_ctrl_t                          ctrl,
	input  logic [KEY_W-1:0]                  key_value,
	input  logic [KEY_BYTES_W-1:0]            key_bytes,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0]   num_keys,
	output logic                              we,
	output logic [$clog2(MAX_ROUNDS)-1:0]     waddr,
	output logic [WORD_W-1:0]                 wdata,
	output logic                              last
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int AW = $clog2(MAX_ROUNDS);

	logic [KEY_W-1:0]       sr_q;
	logic [Z0_PERIOD-1:0]   z_q;
	logic [RW-1:0]          cnt_q;
	logic [KEY_W-1:0]       key_masked;
	logic [KEY_BYTES_W-1:0] nbytes;
	logic [WORD_W-1:0]      tmp;
	logic [WORD_W-1:0]      new_word;

	// Bytes beyond the configured key length read as zero.
	always_comb begin
		nbytes = (key_bytes > KEY_BYTES_W'(8)) ? KEY_BYTES_W'(8) : key_bytes;
		for (int j = 0; j < 8; j++) begin
			key_masked[8*j +: 8] = (KEY_BYTES_W'(j) < nbytes) ? key_value[8*j +: 8] : 8'h00;
		end
	end

	// The low word is k[i]; the word for k[i+4] enters at the top.
	always_comb begin
		tmp      = ror16(sr_q[63:48], 3) ^ sr_q[31:16];
		new_word = ~sr_q[15:0] ^ tmp ^ ror16(tmp, 1) ^ RK_CONST ^ {{(WORD_W-1){1'b0}}, z_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sr_q <= key_masked;
			z_q  <= Z0_SEQ[Z0_PERIOD-1:0];
		end else if (ctrl.step) begin
			sr_q <= {new_word, sr_q[KEY_W-1:WORD_W]};
			z_q  <= {z_q[0], z_q[Z0_PERIOD-1:1]};
		end
	end

	assign we    = ctrl.step;
	assign waddr = cnt_q[AW-1:0];
	assign wdata = sr_q[WORD_W-1:0];
	assign last  = (cnt_q == num_keys - RW'(1));

endmodule

FILE: sv/sim32_rounds.sv
// Round datapath: two word registers that take one Feistel round per cycle, plus
// the round counter and the key table read address. Depends on sim32_pkg.
module sim32_rounds import sim32_pkg::*; #(
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rnd_ctrl_t                       ctrl,
	input  logic                            op,
	input  logic [BLOCK_W-1:0]              block_in,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0] rounds,
	input  logic [WORD_W-1:0]               round_key,
	output logic [$clog2(MAX_ROUNDS)-1:0]   raddr,
	output logic [BLOCK_W-1:0]              result,
	output logic                            last
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int AW = $clog2(MAX_ROUNDS);

	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic              dec_q;
	logic [RW-1:0]     cnt_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     addr_next;
	logic [RW-1:0]     rounds_m1;

	assign rounds_m1 = rounds - RW'(1);
	assign addr_next = dec_q ? addr_q - AW'(1) : addr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + RW'(1);
		end
	end

	// Decryption walks the key table from the top down and runs the inverse round.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q    <= block_in[BLOCK_W-1:WORD_W];
			y_q    <= block_in[WORD_W-1:0];
			dec_q  <= op;
			addr_q <= op ? rounds_m1[AW-1:0] : '0;
		end else begin
			if (ctrl.prime || ctrl.step) begin
				addr_q <= addr_next;
			end
			if (ctrl.step) begin
				if (dec_q) begin
					x_q <= y_q;
					y_q <= x_q ^ simon_f(y_q) ^ round_key;
				end else begin
					x_q <= y_q ^ simon_f(x_q) ^ round_key;
					y_q <= x_q;
				end
			end
		end
	end

	assign raddr  = addr_q;
	assign result = {x_q, y_q};
	assign last   = (cnt_q == rounds_m1);

endmodule

FILE: sv/simon32_block_cipher.sv
// Simon 32/64 block cipher, one Feistel round per cycle with round keys from a RAM.
// A request passes through the prime state, R rounds and the done state, R the effective
// round count (32 by default); the next request is taken only once the result is registered.
// After reset and after every register write the max(R, 4) round keys are expanded,
// one key per cycle, while no request is taken.
// Reset is asynchronous and active low; key 0, 8 key bytes and 32 rounds after it.
module simon32_block_cipher import sim32_pkg::*; #(
	parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sim32_req_if.sink     req,
	sim32_rsp_if.source   rsp,
	sim32_cfg_if.sink     cfg
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int AW = $clog2(MAX_ROUNDS);
	localparam int CW = (RW > ROUND_COUNT_W) ? RW : ROUND_COUNT_W;

	state_t                   state_q;
	state_t                   state_d;
	logic [KEY_W-1:0]         key_value_q;
	logic [KEY_BYTES_W-1:0]   key_bytes_q;
	logic [ROUND_COUNT_W-1:0] round_count_q;
	logic                     out_valid_q;
	logic [BLOCK_W-1:0]       block_out_q;

	logic [RW-1:0]     rounds;
	logic [RW-1:0]     num_keys;
	logic              cfg_wr;
	logic              out_load;
	ks_ctrl_t          ks_ctrl;
	rnd_ctrl_t         rnd_ctrl;
	logic              ks_we;
	logic [AW-1:0]     ks_waddr;
	logic [WORD_W-1:0] ks_wdata;
	logic              ks_last;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_key;
	logic [BLOCK_W-1:0] result;
	logic              rnd_last;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_value_q   <= '0;
			key_bytes_q   <= KEY_BYTES_W'(8);
			round_count_q <= ROUND_COUNT_W'(DEFAULT_ROUNDS);
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_KEY_VALUE:   key_value_q   <= cfg.data;
				REG_KEY_BYTES:   key_bytes_q   <= cfg.data[KEY_BYTES_W-1:0];
				REG_ROUND_COUNT: round_count_q <= cfg.data[ROUND_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero selects the default round count; anything above the table depth saturates.
	always_comb begin
		if (round_count_q == '0) begin
			rounds = (DEFAULT_ROUNDS > MAX_ROUNDS) ? RW'(MAX_ROUNDS) : RW'(DEFAULT_ROUNDS);
		end else if (CW'(round_count_q) > CW'(MAX_ROUNDS)) begin
			rounds = RW'(MAX_ROUNDS);
		end else begin
			rounds = RW'(round_count_q);
		end
		num_keys = (rounds < RW'(4)) ? RW'(4) : rounds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KSTART;
		end else begin
			state_q <= state_d;
		end
	end

	// Any register write, even one to an unknown index, restarts key expansion.
	always_comb begin
		state_d = state_q;
		if (cfg_wr) begin
			state_d = ST_KSTART;
		end else begin
			unique case (state_q)
				ST_KSTART: state_d = ST_EXPAND;
				ST_EXPAND: if (ks_last) state_d = ST_IDLE;
				ST_IDLE:   if (req.valid) state_d = ST_PRIME;
				ST_PRIME:  state_d = ST_RUN;
				ST_RUN:    if (rnd_last) state_d = ST_DONE;
				ST_DONE:   if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
				default:   state_d = ST_KSTART;
			endcase
		end
	end

	always_comb begin
		req.ready      = (state_q == ST_IDLE);
		ks_ctrl.load   = (state_q == ST_KSTART);
		ks_ctrl.step   = (state_q == ST_EXPAND);
		rnd_ctrl.load  = (state_q == ST_IDLE) && req.valid;
		rnd_ctrl.prime = (state_q == ST_PRIME);
		rnd_ctrl.step  = (state_q == ST_RUN);
		out_load       = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	end

	sim32_keysched #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_keysched (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ks_ctrl),
		.key_value(key_value_q),
		.key_bytes(key_bytes_q),
		.num_keys (num_keys),
		.we       (ks_we),
		.waddr    (ks_waddr),
		.wdata    (ks_wdata),
		.last     (ks_last)
	);

	sim32_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ROUNDS)
	) u_key_ram (
		.clk  (clk),
		.we   (ks_we),
		.waddr(ks_waddr),
		.wdata(ks_wdata),
		.raddr(rd_addr),
		.rdata(rd_key)
	);

	sim32_rounds #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_rounds (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rnd_ctrl),
		.op       (req.op),
		.block_in (req.block_in),
		.rounds   (rounds),
		.round_key(rd_key),
		.raddr    (rd_addr),
		.result   (result),
		.last     (rnd_last)
	);

	// The result register frees the round datapath while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			block_out_q <= result;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.block_out = block_out_q;

	a_no_key_write_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME || state_q == ST_RUN || state_q == ST_DONE) |-> !ks_we)
		else $error("round key RAM written while a request is in flight");

	a_cfg_restarts_expansion: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (state_q == ST_KSTART))
		else $error("register write did not restart key expansion");

	a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !cfg_wr) |=> (state_q == ST_PRIME))
		else $error("accepted request did not start the round loop");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result presented without finishing the rounds");

endmodule
